### sv/fst_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Frame sequence timer package
// Shared types, command and register codes, and the table index reduction.
// ----------------------------------------------------------------------------
package fst_pkg;

  localparam int unsigned DEF_TABLE_DEPTH = 64;

  localparam int unsigned CMD_W    = 3;
  localparam int unsigned FRAME_W  = 8;
  localparam int unsigned TIDX_W   = 6;
  localparam int unsigned TICKS_W  = 16;
  localparam int unsigned LOOP_W   = 17;
  localparam int unsigned LIMIT_W  = 16;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 16;

  localparam logic [CMD_W-1:0] CMD_TICK      = 3'd0;
  localparam logic [CMD_W-1:0] CMD_START     = 3'd1;
  localparam logic [CMD_W-1:0] CMD_RESUME    = 3'd2;
  localparam logic [CMD_W-1:0] CMD_STOP      = 3'd3;
  localparam logic [CMD_W-1:0] CMD_SET_FRAME = 3'd4;
  localparam logic [CMD_W-1:0] CMD_WRITE_DUR = 3'd5;

  localparam logic [CFG_IDX_W-1:0] CFG_FIRST_FRAME = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_LAST_FRAME  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_LOOP_LIMIT  = 2'd2;

  localparam logic [TICKS_W-1:0] DEFAULT_TICKS = 16'd1000;
  localparam logic [LOOP_W-1:0]  LOOP_SAT      = 17'h10000;

  typedef struct packed {
    logic [CMD_W-1:0]   command;
    logic [FRAME_W-1:0] frame_value;
    logic [TIDX_W-1:0]  table_index;
    logic [TICKS_W-1:0] duration_ticks;
  } item_t;

  typedef struct packed {
    logic [FRAME_W-1:0] frame;
    logic [LOOP_W-1:0]  loop_number;
    logic               running;
    logic               frame_changed;
    logic               run_state_changed;
    logic               finished;
  } result_t;

  typedef struct packed {
    logic we;
    logic re;
  } tbl_ctrl_t;

  // Remainder of an 8-bit value by a constant depth d, with m = 2^16 / d + 1 as
  // the reciprocal. The quotient estimate is exact for every 8-bit value and
  // every depth up to 256.
  function automatic logic [7:0] mod_depth(input logic [7:0] v, input logic [8:0] d,
                                           input logic [16:0] m);
    logic [24:0] prod;
    logic [17:0] qd;
    prod = {17'd0, v} * {8'd0, m};
    qd   = {10'd0, prod[23:16]} * {9'd0, d};
    return v - qd[7:0];
  endfunction

endpackage

### sv/fst_in_reg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Frame sequence timer input register
// Holds one accepted transaction until the sequencer stage takes it.
// ----------------------------------------------------------------------------
module fst_in_reg (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  input  fst_pkg::item_t in_item,
  input  logic          take,
  output logic          s1_valid,
  output fst_pkg::item_t s1_item
);

  logic           valid_r;
  fst_pkg::item_t item_r;

  assign in_ready = !valid_r || take;
  assign s1_valid = valid_r;
  assign s1_item  = item_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_ready) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item_r <= in_item;
    end
  end

endmodule

### sv/fst_dur_table.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Frame sequence timer duration table
// Single-port write, registered read memory with per-entry valid bits.
// An entry that was never written reads as the default duration.
// ----------------------------------------------------------------------------
module fst_dur_table #(
  parameter int unsigned TABLE_DEPTH = fst_pkg::DEF_TABLE_DEPTH,
  parameter int unsigned AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  fst_pkg::tbl_ctrl_t           ctrl,
  input  logic [AW-1:0]                waddr,
  input  logic [fst_pkg::TICKS_W-1:0]  wdata,
  input  logic [AW-1:0]                raddr,
  output logic [fst_pkg::TICKS_W-1:0]  rdata
);

  logic [fst_pkg::TICKS_W-1:0] mem [TABLE_DEPTH];
  logic [TABLE_DEPTH-1:0]      valid_r;
  logic [fst_pkg::TICKS_W-1:0] rd_data_r;
  logic                        rd_vld_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else if (ctrl.we) begin
      valid_r[waddr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.we) begin
      mem[waddr] <= wdata;
    end
    if (ctrl.re) begin
      rd_data_r <= mem[raddr];
      rd_vld_r  <= valid_r[raddr];
    end
  end

  assign rdata = rd_vld_r ? rd_data_r : fst_pkg::DEFAULT_TICKS;

endmodule

### sv/fst_seq_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Frame sequence timer sequencer
// Holds frame, loop count, running flag and tick counter, and computes the
// next state and the result for each transaction. A newly armed duration
// comes from the registered table read port and serves the next transaction.
// ----------------------------------------------------------------------------
module fst_seq_core #(
  parameter int unsigned TABLE_DEPTH = fst_pkg::DEF_TABLE_DEPTH,
  parameter int unsigned AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         fire,
  input  fst_pkg::item_t               item,
  input  logic [fst_pkg::FRAME_W-1:0]  first_frame,
  input  logic [fst_pkg::FRAME_W-1:0]  last_frame,
  input  logic [fst_pkg::LIMIT_W-1:0]  loop_limit,
  input  logic [fst_pkg::TICKS_W-1:0]  tbl_rdata,
  output fst_pkg::tbl_ctrl_t           tbl_ctrl,
  output logic [AW-1:0]                tbl_waddr,
  output logic [fst_pkg::TICKS_W-1:0]  tbl_wdata,
  output logic [AW-1:0]                tbl_raddr,
  output fst_pkg::result_t             result
);

  localparam logic [8:0]  DEPTH_C = 9'(TABLE_DEPTH);
  localparam logic [16:0] RECIP_C = 17'((32'd65536 / TABLE_DEPTH) + 32'd1);

  logic [fst_pkg::FRAME_W-1:0] frame_r, frame_nxt;
  logic [fst_pkg::LOOP_W-1:0]  loop_r, loop_nxt;
  logic                        run_r, run_nxt;
  logic [fst_pkg::TICKS_W-1:0] ticks_r, ticks_nxt;
  logic                        pend_r, pend_nxt;

  logic [fst_pkg::TICKS_W-1:0] ticks_eff;
  logic [fst_pkg::FRAME_W:0]   frame_inc;
  logic [fst_pkg::FRAME_W-1:0] frame_ofs;
  logic                        arm, wr;
  logic                        fchg, rchg, fin;

  always_comb begin
    if (pend_r) begin
      ticks_eff = (tbl_rdata == '0) ? fst_pkg::TICKS_W'(1) : tbl_rdata;
    end else begin
      ticks_eff = ticks_r;
    end
  end

  assign frame_inc = {1'b0, frame_r} + 9'd1;

  always_comb begin
    frame_nxt = frame_r;
    loop_nxt  = loop_r;
    run_nxt   = run_r;
    ticks_nxt = ticks_eff;
    arm       = 1'b0;
    wr        = 1'b0;
    fchg      = 1'b0;
    rchg      = 1'b0;
    fin       = 1'b0;
    unique case (item.command)
      fst_pkg::CMD_TICK: begin
        if (ticks_eff != '0) begin
          ticks_nxt = ticks_eff - fst_pkg::TICKS_W'(1);
          if (ticks_eff == fst_pkg::TICKS_W'(1)) begin
            if (frame_inc > {1'b0, last_frame}) begin
              frame_nxt = first_frame;
              if (loop_r < fst_pkg::LOOP_SAT) begin
                loop_nxt = loop_r + fst_pkg::LOOP_W'(1);
              end
            end else begin
              frame_nxt = frame_inc[fst_pkg::FRAME_W-1:0];
            end
            if ((loop_limit != '0) && (loop_nxt > {1'b0, loop_limit})) begin
              fin       = 1'b1;
              run_nxt   = 1'b0;
              rchg      = run_r;
              ticks_nxt = '0;
            end else begin
              fchg = 1'b1;
              arm  = 1'b1;
            end
          end
        end
      end
      fst_pkg::CMD_START: begin
        run_nxt   = 1'b1;
        rchg      = !run_r;
        fchg      = (frame_r != first_frame);
        frame_nxt = first_frame;
        loop_nxt  = '0;
        arm       = 1'b1;
      end
      fst_pkg::CMD_RESUME: begin
        if (!run_r) begin
          run_nxt = 1'b1;
          rchg    = 1'b1;
          arm     = 1'b1;
        end
      end
      fst_pkg::CMD_STOP: begin
        if (run_r) begin
          run_nxt   = 1'b0;
          rchg      = 1'b1;
          ticks_nxt = '0;
        end
      end
      fst_pkg::CMD_SET_FRAME: begin
        if (frame_r != item.frame_value) begin
          frame_nxt = item.frame_value;
          fchg      = 1'b1;
        end
      end
      fst_pkg::CMD_WRITE_DUR: begin
        wr = 1'b1;
      end
      default: begin
      end
    endcase
    pend_nxt = arm;
    if (arm) begin
      ticks_nxt = '0;
    end
  end

  assign frame_ofs   = frame_nxt - first_frame;
  assign tbl_raddr   = AW'(fst_pkg::mod_depth(frame_ofs, DEPTH_C, RECIP_C));
  assign tbl_waddr   = AW'(fst_pkg::mod_depth({2'b00, item.table_index}, DEPTH_C, RECIP_C));
  assign tbl_wdata   = item.duration_ticks;
  assign tbl_ctrl.we = fire && wr;
  assign tbl_ctrl.re = fire && arm;

  assign result.frame             = frame_nxt;
  assign result.loop_number       = loop_nxt;
  assign result.running           = run_nxt;
  assign result.frame_changed     = fchg;
  assign result.run_state_changed = rchg;
  assign result.finished          = fin;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_r <= '0;
      loop_r  <= '0;
      run_r   <= 1'b0;
      ticks_r <= '0;
      pend_r  <= 1'b0;
    end else if (fire) begin
      frame_r <= frame_nxt;
      loop_r  <= loop_nxt;
      run_r   <= run_nxt;
      ticks_r <= ticks_nxt;
      pend_r  <= pend_nxt;
    end
  end

endmodule

### sv/fst_out_reg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Frame sequence timer result register
// Holds one result transaction until the receiver takes it.
// ----------------------------------------------------------------------------
module fst_out_reg (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             load,
  input  fst_pkg::result_t load_result,
  output logic             can_load,
  output logic             out_valid,
  input  logic             out_ready,
  output fst_pkg::result_t out_result
);

  logic             valid_r;
  fst_pkg::result_t result_r;

  assign can_load   = !valid_r || out_ready;
  assign out_valid  = valid_r;
  assign out_result = result_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (can_load) begin
      valid_r <= load;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      result_r <= load_result;
    end
  end

endmodule

### sv/frame_sequence_timer_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Frame sequence timer
// Steps through frames, each held for a programmable number of 1 ms ticks.
//
// The input channel carries one command per transaction: tick, start, resume,
// stop, set frame or write duration. Every input transaction yields exactly
// one result transaction with the frame, loop count, running flag and the
// frame change, run state change and finished indications.
// An input register feeds the sequencer, whose result lands in an output
// register, and one transaction is accepted every cycle while out_ready is
// high. The table read port is registered; a duration armed by one
// transaction is used by the next one.
// When the receiver stalls, the output register holds its result and the
// input register fills, after which in_ready drops until out_ready returns.
// Synchronous reset clears the frame, loop count, running flag and timer,
// the configuration registers, and marks every table entry as holding the
// default of 1000 ticks. Configuration must be written while idle.
// ----------------------------------------------------------------------------
module frame_sequence_timer_unit #(
  parameter int unsigned TABLE_DEPTH = fst_pkg::DEF_TABLE_DEPTH
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [fst_pkg::CMD_W-1:0]       in_command,
  input  logic [fst_pkg::FRAME_W-1:0]     in_frame_value,
  input  logic [fst_pkg::TIDX_W-1:0]      in_table_index,
  input  logic [fst_pkg::TICKS_W-1:0]     in_duration_ticks,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [fst_pkg::FRAME_W-1:0]     out_frame,
  output logic [fst_pkg::LOOP_W-1:0]      out_loop_number,
  output logic                            out_running,
  output logic                            out_frame_changed,
  output logic                            out_run_state_changed,
  output logic                            out_finished,
  input  logic                            cfg_we,
  input  logic [fst_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [fst_pkg::CFG_DATA_W-1:0]  cfg_data
);

  localparam int unsigned AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

  logic [fst_pkg::FRAME_W-1:0] first_frame_r;
  logic [fst_pkg::FRAME_W-1:0] last_frame_r;
  logic [fst_pkg::LIMIT_W-1:0] loop_limit_r;

  fst_pkg::item_t      in_item;
  fst_pkg::item_t      s1_item;
  logic                s1_valid;
  logic                s1_fire;
  logic                can_load;
  fst_pkg::result_t    core_result;
  fst_pkg::result_t    out_result;
  fst_pkg::tbl_ctrl_t  tbl_ctrl;
  logic [AW-1:0]       tbl_waddr;
  logic [AW-1:0]       tbl_raddr;
  logic [fst_pkg::TICKS_W-1:0] tbl_wdata;
  logic [fst_pkg::TICKS_W-1:0] tbl_rdata;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      first_frame_r <= '0;
      last_frame_r  <= '0;
      loop_limit_r  <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        fst_pkg::CFG_FIRST_FRAME: first_frame_r <= cfg_data[fst_pkg::FRAME_W-1:0];
        fst_pkg::CFG_LAST_FRAME:  last_frame_r  <= cfg_data[fst_pkg::FRAME_W-1:0];
        fst_pkg::CFG_LOOP_LIMIT:  loop_limit_r  <= cfg_data[fst_pkg::LIMIT_W-1:0];
        default: begin
        end
      endcase
    end
  end

  assign in_item.command        = in_command;
  assign in_item.frame_value    = in_frame_value;
  assign in_item.table_index    = in_table_index;
  assign in_item.duration_ticks = in_duration_ticks;

  assign s1_fire = s1_valid && can_load;

  fst_in_reg u_in_reg (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_item  (in_item),
    .take     (s1_fire),
    .s1_valid (s1_valid),
    .s1_item  (s1_item)
  );

  fst_dur_table #(
    .TABLE_DEPTH (TABLE_DEPTH),
    .AW          (AW)
  ) u_dur_table (
    .clk   (clk),
    .rst_n (rst_n),
    .ctrl  (tbl_ctrl),
    .waddr (tbl_waddr),
    .wdata (tbl_wdata),
    .raddr (tbl_raddr),
    .rdata (tbl_rdata)
  );

  fst_seq_core #(
    .TABLE_DEPTH (TABLE_DEPTH),
    .AW          (AW)
  ) u_seq_core (
    .clk         (clk),
    .rst_n       (rst_n),
    .fire        (s1_fire),
    .item        (s1_item),
    .first_frame (first_frame_r),
    .last_frame  (last_frame_r),
    .loop_limit  (loop_limit_r),
    .tbl_rdata   (tbl_rdata),
    .tbl_ctrl    (tbl_ctrl),
    .tbl_waddr   (tbl_waddr),
    .tbl_wdata   (tbl_wdata),
    .tbl_raddr   (tbl_raddr),
    .result      (core_result)
  );

  fst_out_reg u_out_reg (
    .clk         (clk),
    .rst_n       (rst_n),
    .load        (s1_fire),
    .load_result (core_result),
    .can_load    (can_load),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_result  (out_result)
  );

  assign out_frame             = out_result.frame;
  assign out_loop_number       = out_result.loop_number;
  assign out_running           = out_result.running;
  assign out_frame_changed     = out_result.frame_changed;
  assign out_run_state_changed = out_result.run_state_changed;
  assign out_finished          = out_result.finished;

`ifndef NO_ASSERTIONS
  a_finish_stops: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_finished |-> !out_running && !out_frame_changed)
    else $error("finished result still running or announcing a frame");

  a_start_runs: assert property (@(posedge clk) disable iff (!rst_n)
    s1_fire && (s1_item.command == fst_pkg::CMD_START) |=> out_valid && out_running)
    else $error("start transaction did not produce a running result");

  a_empty_stage_ready: assert property (@(posedge clk) disable iff (!rst_n)
    !s1_valid |-> in_ready)
    else $error("input not ready while the input register is empty");

  a_no_table_conflict: assert property (@(posedge clk) disable iff (!rst_n)
    !(tbl_ctrl.we && tbl_ctrl.re))
    else $error("table written and armed by the same transaction");
`endif

endmodule
